>>> rtl/prp_pkg.sv
// -----------------------------------------------------------------------------
// prp_pkg
// Shared types, constants and lookup functions of the price document tag
// parser: tag texts, parse modes, byte classes and decimal scale factors.
// -----------------------------------------------------------------------------
package prp_pkg;

   localparam int POINT_COUNT     = 24;
   localparam int TEXT_LIMIT      = 64;
   localparam int FRACTION_DIGITS = 3;

   localparam int TEXT_W  = $clog2(TEXT_LIMIT);
   localparam int SLOT_W  = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
   localparam int FRAC_W  = (FRACTION_DIGITS < 1) ? 1 : $clog2(FRACTION_DIGITS + 1);
   localparam int POW_W   = 20;
   localparam int CMP_W   = 9;
   localparam int TAG_MAX = 25;

   localparam logic [31:0] MAG_CAP = 32'h8000_0000;
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [7:0]  NO_SLOT = 8'hFF;

   localparam logic [7:0] CHR_LT    = 8'h3C;
   localparam logic [7:0] CHR_GT    = 8'h3E;
   localparam logic [7:0] CHR_DOT   = 8'h2E;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;

   localparam logic [1:0] TAG_CUR  = 2'd0;
   localparam logic [1:0] TAG_UNIT = 2'd1;
   localparam logic [1:0] TAG_POS  = 2'd2;
   localparam logic [1:0] TAG_AMT  = 2'd3;

   localparam logic [8*TAG_MAX-1:0] TXT_CUR  = {"<currency", "_Unit.name>"};
   localparam logic [8*TAG_MAX-1:0] TXT_UNIT = {"<price_Measure", "_Unit.name>"};
   localparam logic [8*TAG_MAX-1:0] TXT_POS  = "<position>";
   localparam logic [8*TAG_MAX-1:0] TXT_AMT  = "<price.amount>";

   typedef enum logic [4:0] {
      MODE_SEEK = 5'b00001,
      MODE_CUR  = 5'b00010,
      MODE_UNIT = 5'b00100,
      MODE_POS  = 5'b01000,
      MODE_AMT  = 5'b10000
   } mode_type;

   typedef struct packed {
      logic       is_read;
      logic [4:0] sel;
      logic [7:0] data;
      logic       is_lt;
      logic       is_gt;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_blank;
      logic       is_sign;
      logic       is_minus;
      logic       is_dot;
   } item_type;

   typedef struct packed {
      logic stop;
      logic point;
      logic neg;
      logic started;
   } nflag_type;

   function automatic logic [TEXT_W:0] tag_len(input logic [1:0] t);
      logic [TEXT_W:0] len;
      unique case (t)
         TAG_CUR:  len = (TEXT_W + 1)'(20);
         TAG_UNIT: len = (TEXT_W + 1)'(25);
         TAG_POS:  len = (TEXT_W + 1)'(10);
         default:  len = (TEXT_W + 1)'(14);
      endcase
      return len;
   endfunction

   function automatic mode_type tag_mode(input logic [1:0] t);
      mode_type m;
      unique case (t)
         TAG_CUR:  m = MODE_CUR;
         TAG_UNIT: m = MODE_UNIT;
         TAG_POS:  m = MODE_POS;
         default:  m = MODE_AMT;
      endcase
      return m;
   endfunction

   function automatic logic [7:0] tag_char(input logic [1:0] t, input logic [TEXT_W-1:0] n);
      logic [8*TAG_MAX-1:0] txt;
      int                   len;
      logic [7:0]           c;
      unique case (t)
         TAG_CUR:  txt = TXT_CUR;
         TAG_UNIT: txt = TXT_UNIT;
         TAG_POS:  txt = TXT_POS;
         default:  txt = TXT_AMT;
      endcase
      len = int'(tag_len(t));
      c   = 8'h00;
      if (int'(n) < len) begin
         c = txt[8*(len - 1 - int'(n)) +: 8];
      end
      return c;
   endfunction

   function automatic logic [POW_W-1:0] pow_ten(input logic [FRAC_W-1:0] k);
      logic [POW_W-1:0] p;
      case (int'(k))
         0:       p = POW_W'(1);
         1:       p = POW_W'(10);
         2:       p = POW_W'(100);
         3:       p = POW_W'(1000);
         4:       p = POW_W'(10000);
         5:       p = POW_W'(100000);
         default: p = POW_W'(1000000);
      endcase
      return p;
   endfunction

endpackage

>>> rtl/prp_front.sv
// -----------------------------------------------------------------------------
// prp_front
// Accepts requests, classifies document bytes and holds them in a two-entry
// queue for the parse stage.
// -----------------------------------------------------------------------------
module prp_front import prp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type    entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   item_type    cls;
   logic        push;
   logic [7:0]  b;

   assign b = req_tdata[7:0];

   always_comb begin
      cls          = '0;
      cls.is_read  = req_tuser;
      cls.sel      = req_tdata[12:8];
      cls.data     = b;
      cls.is_lt    = (b == CHR_LT);
      cls.is_gt    = (b == CHR_GT);
      cls.is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
      cls.digit    = 4'(b - CHR_ZERO);
      cls.is_blank = (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
      cls.is_sign  = (b == CHR_PLUS) || (b == CHR_MINUS);
      cls.is_minus = (b == CHR_MINUS);
      cls.is_dot   = (b == CHR_DOT);
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

>>> rtl/prp_back.sv
// -----------------------------------------------------------------------------
// prp_back
// Parse stage: tag matching, code capture, number accumulation, the price
// store and the registered response.
// -----------------------------------------------------------------------------
module prp_back import prp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata
);

   mode_type          mode_ff, mode_in;
   logic [TEXT_W-1:0] text_ff, text_in;
   logic [3:0]        cand_ff, cand_in;
   logic [23:0]       shift_ff, shift_in;
   logic [31:0]       accum_ff, accum_in;
   nflag_type         flag_ff, flag_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [7:0]        slot_ff, slot_in;
   logic [POINT_COUNT-1:0] pvalid_ff, pvalid_in;
   logic [23:0]       cur_ff, cur_in;
   logic [23:0]       unit_ff, unit_in;
   logic              out_valid_ff, out_valid_in;
   logic [31:0]       out_value_ff, out_value_in;
   logic              out_flag_ff, out_flag_in;
   logic [23:0]       out_cur_ff;
   logic [23:0]       out_unit_ff;

   logic [31:0]       store_ff [POINT_COUNT];
   logic              we;
   logic [SLOT_W-1:0] widx;
   logic [31:0]       wdata;

   logic [TEXT_W:0]   count_inc;
   logic [35:0]       acc_x10;
   logic [31:0]       acc_step;
   logic [FRAC_W-1:0] missing;
   logic [31+POW_W:0] scaled;
   logic [31:0]       mag;
   logic [31:0]       amt_val;
   logic              pos_bad;
   logic [31:0]       acc_less;
   logic [23:0]       shift_new;
   logic [SLOT_W-1:0] rd_idx;
   logic              rd_hit;
   logic              slot_ok;

   assign q_pop = q_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      count_inc = {1'b0, text_ff} + (TEXT_W + 1)'(1);
      acc_x10   = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1) + {32'b0, q_item.digit};
      acc_step  = (acc_x10 > {4'b0, MAG_CAP}) ? MAG_CAP : acc_x10[31:0];
      missing   = FRAC_W'(FRACTION_DIGITS) - frac_ff;
      scaled    = {{POW_W{1'b0}}, accum_ff} * {32'b0, pow_ten(missing)};
      mag       = (scaled > {{POW_W{1'b0}}, MAG_CAP}) ? MAG_CAP : scaled[31:0];
      amt_val   = flag_ff.neg ? (32'd0 - mag) : (mag[31] ? POS_MAX : mag);
      acc_less  = accum_ff - 32'd1;
      pos_bad   = flag_ff.neg || (accum_ff == 32'd0) ||
                  (accum_ff > 32'(POINT_COUNT)) || (acc_less >= {24'b0, NO_SLOT});
      shift_new = {shift_ff[15:0], q_item.data};
      slot_ok   = ({1'b0, slot_ff} < CMP_W'(POINT_COUNT));
      rd_idx    = SLOT_W'(q_item.sel);
      rd_hit    = ({4'b0, q_item.sel} < CMP_W'(POINT_COUNT)) && pvalid_ff[rd_idx];
   end

   always_comb begin
      mode_in   = mode_ff;
      text_in   = text_ff;
      cand_in   = cand_ff;
      shift_in  = shift_ff;
      accum_in  = accum_ff;
      flag_in   = flag_ff;
      frac_in   = frac_ff;
      slot_in   = slot_ff;
      pvalid_in = pvalid_ff;
      cur_in    = cur_ff;
      unit_in   = unit_ff;
      we        = 1'b0;
      widx      = slot_ff[SLOT_W-1:0];
      wdata     = amt_val;

      if (q_pop && !q_item.is_read) begin
         unique case (mode_ff) inside
            MODE_SEEK: begin
               if (text_ff == '0) begin
                  if (q_item.is_lt) begin
                     text_in = TEXT_W'(1);
                     cand_in = 4'hF;
                  end
               end else if (q_item.is_gt) begin
                  mode_in = MODE_SEEK;
                  for (int i = 0; i < 4; i++) begin
                     if (cand_ff[i] && (tag_len(2'(i)) == count_inc)) begin
                        mode_in = tag_mode(2'(i));
                     end
                  end
                  cand_in  = 4'h0;
                  shift_in = 24'h0;
                  accum_in = 32'd0;
                  flag_in  = '0;
                  frac_in  = '0;
                  text_in  = '0;
                  if (mode_in == MODE_POS) begin
                     slot_in = NO_SLOT;
                  end
               end else begin
                  for (int i = 0; i < 4; i++) begin
                     if (({1'b0, text_ff} >= tag_len(2'(i))) ||
                         (tag_char(2'(i), text_ff) != q_item.data)) begin
                        cand_in[i] = 1'b0;
                     end
                  end
                  text_in = count_inc[TEXT_W-1:0];
                  if (count_inc >= (TEXT_W + 1)'(TEXT_LIMIT)) begin
                     text_in = '0;
                     cand_in = 4'h0;
                  end
               end
            end
            MODE_CUR, MODE_UNIT: begin
               if (count_inc >= (TEXT_W + 1)'(3)) begin
                  if (mode_ff == MODE_CUR) begin
                     cur_in = shift_new;
                  end else begin
                     unit_in = shift_new;
                  end
                  shift_in = 24'h0;
                  text_in  = '0;
                  mode_in  = MODE_SEEK;
               end else begin
                  shift_in = shift_new;
                  text_in  = count_inc[TEXT_W-1:0];
               end
            end
            MODE_POS, MODE_AMT: begin
               if (q_item.is_lt) begin
                  if (mode_ff == MODE_AMT) begin
                     if (slot_ok) begin
                        we                  = 1'b1;
                        pvalid_in[widx]     = 1'b1;
                     end
                  end else begin
                     slot_in = pos_bad ? NO_SLOT : acc_less[7:0];
                  end
                  accum_in = 32'd0;
                  flag_in  = '0;
                  frac_in  = '0;
                  text_in  = '0;
                  mode_in  = MODE_SEEK;
               end else begin
                  if (!flag_ff.stop) begin
                     if (q_item.is_digit) begin
                        flag_in.started = 1'b1;
                        if (flag_ff.point) begin
                           if (int'(frac_ff) < FRACTION_DIGITS) begin
                              accum_in = acc_step;
                              frac_in  = frac_ff + FRAC_W'(1);
                           end
                        end else begin
                           accum_in = acc_step;
                        end
                     end else if (!flag_ff.started && q_item.is_blank) begin
                        flag_in = flag_ff;
                     end else if (!flag_ff.started && q_item.is_sign) begin
                        flag_in.started = 1'b1;
                        flag_in.neg     = q_item.is_minus;
                     end else if ((mode_ff == MODE_AMT) && q_item.is_dot && !flag_ff.point) begin
                        flag_in.started = 1'b1;
                        flag_in.point   = 1'b1;
                     end else begin
                        flag_in.stop = 1'b1;
                     end
                  end
                  text_in = count_inc[TEXT_W-1:0];
                  if (count_inc >= (TEXT_W + 1)'(TEXT_LIMIT)) begin
                     accum_in = 32'd0;
                     flag_in  = '0;
                     frac_in  = '0;
                     text_in  = '0;
                  end
               end
            end
            default: begin
               mode_in = MODE_SEEK;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_flag_in  = out_flag_ff;
      if (q_pop) begin
         out_valid_in = 1'b1;
         out_flag_in  = q_item.is_read && rd_hit;
         out_value_in = (q_item.is_read && rd_hit) ? store_ff[rd_idx] : 32'd0;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SEEK;
         text_ff      <= '0;
         cand_ff      <= 4'h0;
         shift_ff     <= 24'h0;
         accum_ff     <= 32'd0;
         flag_ff      <= '0;
         frac_ff      <= '0;
         slot_ff      <= NO_SLOT;
         pvalid_ff    <= '0;
         cur_ff       <= 24'h0;
         unit_ff      <= 24'h0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         text_ff      <= text_in;
         cand_ff      <= cand_in;
         shift_ff     <= shift_in;
         accum_ff     <= accum_in;
         flag_ff      <= flag_in;
         frac_ff      <= frac_in;
         slot_ff      <= slot_in;
         pvalid_ff    <= pvalid_in;
         cur_ff       <= cur_in;
         unit_ff      <= unit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_flag_ff  <= out_flag_in;
      if (q_pop) begin
         out_cur_ff  <= cur_in;
         out_unit_ff <= unit_in;
      end
      if (we) begin
         store_ff[widx] <= wdata;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_unit_ff, out_cur_ff, out_flag_ff, out_value_ff};

endmodule

>>> rtl/price_document_tag_parser.sv
// -----------------------------------------------------------------------------
// price_document_tag_parser
// Markup byte parser that captures currency and unit codes and stores
// position-tagged amounts in thousandths; read requests return a stored price.
// -----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)                          | tuser
//  req_    | in        | data_byte[7:0], point_sel[12:8]              | req_type
//  rsp_    | out       | point_value, point_valid, currency, unit    | -
//
//  One request per cycle sustained while rsp_tready is high; every request gives one response.
//  Requests pass through the queue, then the parse stage into the output register.
//  A two-entry queue lets requests in while a response is held back.
//  Synchronous active-high reset; the price store itself is not cleared.
// -----------------------------------------------------------------------------
module price_document_tag_parser import prp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte[7:0], point_sel[12:8]
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata    // point_value[31:0], point_valid[32],
                                    // currency_code[56:33], unit_code[80:57]
);

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   prp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   prp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> rtl/prp_checker.sv
// -----------------------------------------------------------------------------
// prp_checker
// Port-level checks on the tag parser: response hold, empty-slot encoding,
// reset behaviour, request/response balance and buffer capacity.
// -----------------------------------------------------------------------------
module prp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata
);

   logic [2:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff + 3'(req_tvalid && req_tready) - 3'(rsp_tvalid && rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[32] |-> rsp_tdata[31:0] == 32'd0)
      else $error("price without valid flag is not zero");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_balance: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 3'd0)
      else $error("response without request");

   a_full: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 3'd3 |-> !req_tready)
      else $error("request taken beyond buffer capacity");

endmodule

bind price_document_tag_parser prp_checker u_prp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> test/testbench.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Price document tag parser testbench
// Feeds markup fragments, noise bytes and slot reads through the request
// stream. An in-bench tracker follows the tag and number parsing and queues
// one expected response per request. Responses are compared field by field
// while both stream sides idle and stall at random over several phases.
// -----------------------------------------------------------------------------
module testbench;
   import prp_pkg::*;

   localparam int LIMIT = 200000;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic [31:0] value;
      logic        valid;
      logic [23:0] currency;
      logic [23:0] unit_code;
   } price_reply_type;

   class price_tracker;
      mode_type     mode;
      int unsigned  text_count;
      int unsigned  frac_count;
      logic [3:0]   candidates;
      logic [23:0]  code_shift;
      logic [23:0]  currency;
      logic [23:0]  unit_code;
      logic [31:0]  accum;
      bit           started;
      bit           negative;
      bit           has_point;
      bit           stopped;
      logic [7:0]   slot;
      logic [31:0]  prices [POINT_COUNT];
      bit [POINT_COUNT-1:0] filled;
      price_reply_type pending [$];
      int           errors;
      string        tag_text [4];
      mode_type     tag_target [4];

      function new();
         tag_text[0]   = "<currency";
         tag_text[0]   = {tag_text[0], "_Unit.name>"};
         tag_text[1]   = "<price_Measure";
         tag_text[1]   = {tag_text[1], "_Unit.name>"};
         tag_text[2]   = "<position>";
         tag_text[3]   = "<price.amount>";
         tag_target[0] = MODE_CUR;
         tag_target[1] = MODE_UNIT;
         tag_target[2] = MODE_POS;
         tag_target[3] = MODE_AMT;
         mode       = MODE_SEEK;
         candidates = '0;
         code_shift = '0;
         currency   = '0;
         unit_code  = '0;
         slot       = NO_SLOT;
         filled     = '0;
         errors     = 0;
         clear_number();
      endfunction

      function logic [31:0] scale_add(logic [31:0] a, int unsigned m, int unsigned d);
         logic [63:0] v;
         v = 64'(a) * 64'(m) + 64'(d);
         return (v > 64'h8000_0000) ? 32'h8000_0000 : v[31:0];
      endfunction

      function void clear_number();
         accum      = '0;
         started    = 0;
         negative   = 0;
         has_point  = 0;
         stopped    = 0;
         frac_count = 0;
         text_count = 0;
      endfunction

      function void number_char(logic [7:0] b, bit allow_point);
         if (stopped) return;
         if (b >= CH_ZERO && b <= CH_NINE) begin
            started = 1;
            if (!has_point) begin
               accum = scale_add(accum, 10, b - CH_ZERO);
            end else if (frac_count < FRACTION_DIGITS) begin
               accum = scale_add(accum, 10, b - CH_ZERO);
               frac_count++;
            end
         end else if (!started && (b == CH_SPACE || (b >= 8'd9 && b <= 8'd13))) begin
         end else if (!started && (b == CH_PLUS || b == CH_MINUS)) begin
            started  = 1;
            negative = (b == CH_MINUS);
         end else if (allow_point && b == CH_DOT && !has_point) begin
            started   = 1;
            has_point = 1;
         end else begin
            stopped = 1;
         end
      endfunction

      function void close_amount();
         int unsigned scale;
         logic [31:0] mag;
         logic [31:0] val;
         scale = 1;
         for (int k = frac_count; k < FRACTION_DIGITS; k++) scale = scale * 10;
         mag = scale_add(accum, scale, 0);
         if (negative) val = -mag;
         else val = (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
         if (slot < POINT_COUNT) begin
            prices[slot] = val;
            filled[slot] = 1;
         end
      endfunction

      function void close_position();
         if (negative || accum == 0 || accum > POINT_COUNT) slot = NO_SLOT;
         else slot = 8'(accum - 1);
      endfunction

      function void seek_char(logic [7:0] b);
         mode_type next;
         if (text_count == 0) begin
            if (b == CH_LT) begin
               text_count = 1;
               candidates = '1;
            end
            return;
         end
         if (b == CH_GT) begin
            next = MODE_SEEK;
            for (int i = 0; i < 4; i++)
               if (candidates[i] && tag_text[i].len() == text_count + 1) next = tag_target[i];
            mode       = next;
            candidates = '0;
            code_shift = '0;
            clear_number();
            if (next == MODE_POS) slot = NO_SLOT;
            return;
         end
         for (int i = 0; i < 4; i++)
            if (text_count >= tag_text[i].len() || tag_text[i][text_count] != b)
               candidates[i] = 0;
         text_count++;
         if (text_count >= TEXT_LIMIT) begin
            text_count = 0;
            candidates = '0;
         end
      endfunction

      function void take_request(bit is_read, logic [7:0] b, logic [4:0] sel);
         price_reply_type r;
         r = '0;
         if (!is_read) begin
            case (mode)
               MODE_CUR, MODE_UNIT: begin
                  code_shift = {code_shift[15:0], b};
                  text_count++;
                  if (text_count >= 3) begin
                     if (mode == MODE_CUR) currency = code_shift;
                     else unit_code = code_shift;
                     code_shift = '0;
                     text_count = 0;
                     mode       = MODE_SEEK;
                  end
               end
               MODE_POS, MODE_AMT: begin
                  if (b == CH_LT) begin
                     if (mode == MODE_AMT) close_amount();
                     else close_position();
                     clear_number();
                     mode = MODE_SEEK;
                  end else begin
                     number_char(b, mode == MODE_AMT);
                     text_count++;
                     if (text_count >= TEXT_LIMIT) clear_number();
                  end
               end
               default: seek_char(b);
            endcase
         end else if (sel < POINT_COUNT && filled[sel]) begin
            r.value = prices[sel];
            r.valid = 1;
         end
         r.currency  = currency;
         r.unit_code = unit_code;
         pending.push_back(r);
      endfunction

      function void match_reply(logic [87:0] d);
         price_reply_type want;
         if (pending.size() == 0) begin
            $display("%0t: response with none expected: %h", $time, d);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (d[31:0] !== want.value) begin
            $display("%0t: point_value expected %h got %h", $time, want.value, d[31:0]);
            errors++;
         end
         if (d[32] !== want.valid) begin
            $display("%0t: point_valid expected %b got %b", $time, want.valid, d[32]);
            errors++;
         end
         if (d[56:33] !== want.currency) begin
            $display("%0t: currency_code expected %h got %h", $time, want.currency,
                     d[56:33]);
            errors++;
         end
         if (d[80:57] !== want.unit_code) begin
            $display("%0t: unit_code expected %h got %h", $time, want.unit_code, d[80:57]);
            errors++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [87:0] rsp_tdata;

   price_tracker tracker;
   logic [7:0]   doc [$];
   int           send_idle  = 0;
   int           stall_pct  = 0;
   int           hold_count = 0;
   int           sent_count = 0;
   int           cycles     = 0;

   price_document_tag_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.match_reply(rsp_tdata);
      if (hold_count != 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_request(bit is_read, logic [7:0] b, logic [4:0] sel);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, sel, b};
      req_tuser  <= is_read;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.take_request(is_read, b, sel);
      sent_count++;
   endtask

   task automatic read_slot();
      logic [4:0] s;
      if (tracker.filled != 0 && $urandom_range(1) == 0) begin
         do s = 5'($urandom_range(POINT_COUNT - 1)); while (!tracker.filled[s]);
      end else if ($urandom_range(3) != 0) begin
         s = 5'($urandom_range(POINT_COUNT - 1));
      end else begin
         s = 5'(POINT_COUNT + $urandom_range(31 - POINT_COUNT));
      end
      send_request(1'b1, 8'($urandom), s);
   endtask

   task automatic flush_doc();
      while (doc.size() != 0) begin
         if ($urandom_range(19) == 0) read_slot();
         send_request(1'b0, doc.pop_front(), 5'($urandom));
      end
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
   endtask

   task automatic add_lead();
      int c;
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            c = $urandom_range(9, 14);
            doc.push_back((c == 14) ? CH_SPACE : 8'(c));
         end
      end
      case ($urandom_range(9))
         0: doc.push_back(CH_MINUS);
         1: doc.push_back(CH_PLUS);
         default: ;
      endcase
   endtask

   task automatic add_junk();
      case ($urandom_range(7))
         0: add_text("e3");
         1: add_text(".5");
         2: doc.push_back(8'h00);
         3: add_text("x9");
         4: add_text(" 7");
         default: ;
      endcase
   endtask

   task automatic add_position();
      int v;
      add_lead();
      case ($urandom_range(11))
         0: v = 0;
         1: v = $urandom_range(POINT_COUNT + 1, 99);
         2: v = $urandom_range(250, 300);
         default: v = $urandom_range(1, POINT_COUNT);
      endcase
      if ($urandom_range(7) == 0) doc.push_back(CH_ZERO);
      if ($urandom_range(19) == 0) add_text("99999999999");
      else add_text($sformatf("%0d", v));
      add_junk();
   endtask

   task automatic add_amount();
      int n;
      add_lead();
      n = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 4);
      repeat (n) doc.push_back(8'(CH_ZERO + $urandom_range(9)));
      if ($urandom_range(2) != 0) begin
         doc.push_back(CH_DOT);
         repeat ($urandom_range(6)) doc.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      add_junk();
   endtask

   task automatic random_fragment();
      int pick;
      int t;
      int k;
      pick = $urandom_range(99);
      if (pick < 45) begin
         if ($urandom_range(4) == 0) add_text("<Point>");
         if ($urandom_range(9) != 0) begin
            add_text("<position>");
            add_position();
            add_text("</position>");
         end
         repeat ($urandom_range(1, 2)) begin
            add_text("<price.amount>");
            add_amount();
            add_text("</price.amount>");
         end
      end else if (pick < 65) begin
         t = (pick < 55) ? 0 : 1;
         add_text(tracker.tag_text[t]);
         repeat (3)
            doc.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'(8'h41 + $urandom_range(25)));
         add_text("</x>");
      end else if (pick < 80) begin
         flush_doc();
         repeat ($urandom_range(1, 4)) read_slot();
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(5))
               0: doc.push_back(CH_LT);
               1: doc.push_back(CH_GT);
               default: doc.push_back(8'($urandom));
            endcase
         end
      end else if (pick < 94) begin
         t = $urandom_range(3);
         k = $urandom_range(1, tracker.tag_text[t].len() - 1);
         for (int i = 0; i < k; i++) doc.push_back(tracker.tag_text[t][i]);
         if ($urandom_range(1) == 0) doc.push_back(8'(8'h61 + $urandom_range(25)));
         doc.push_back(CH_GT);
      end else if (pick < 97) begin
         doc.push_back(CH_LT);
         repeat ($urandom_range(TEXT_LIMIT - 2, TEXT_LIMIT + 6))
            doc.push_back(8'(8'h61 + $urandom_range(25)));
         doc.push_back(CH_GT);
      end else begin
         add_text("<price.amount>");
         repeat ($urandom_range(TEXT_LIMIT - 4, TEXT_LIMIT + 6))
            doc.push_back(8'(CH_ZERO + $urandom_range(9)));
         doc.push_back(CH_LT);
      end
      flush_doc();
   endtask

   initial begin
      int phase_end;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_request(1'b1, 8'h00, 5'd31);
      send_request(1'b1, 8'hFF, 5'(POINT_COUNT));
      send_request(1'b1, 8'h3C, 5'd7);
      add_text(tracker.tag_text[0]);
      add_text("EUR");
      add_text(tracker.tag_text[1]);
      doc.push_back(8'hFF);
      doc.push_back(8'h00);
      doc.push_back(CH_LT);
      add_text("><foo><position>1</position><price.amount>-0.0005</price.amount>");
      add_text("<position> +24</position><price.amount>99999999999</price.amount>");
      add_text("<price.amount>-9999999999.9<");
      add_text("<position>0</position><price.amount>5<");
      add_text("<position>25<<price.amount>6<<position>-3<<price.amount>7<");
      add_text("<position>2<<price.amount>1.23456e7<");
      add_text("<position>3<<price.amount>.<");
      doc.push_back(CH_LT);
      repeat (TEXT_LIMIT + 4) doc.push_back(8'h61);
      doc.push_back(CH_GT);
      flush_doc();
      send_request(1'b1, 8'h5A, 5'd0);
      send_request(1'b1, 8'hA5, 5'd1);
      send_request(1'b1, 8'h00, 5'd2);
      send_request(1'b1, 8'hFF, 5'(POINT_COUNT - 1));

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle = 0;
               stall_pct <= 0;
               hold_count <= 300;
            end
            1: begin
               send_idle = 64;
               stall_pct <= 0;
            end
            2: begin
               send_idle = 0;
               stall_pct <= 64;
            end
            default: begin
               send_idle = 19;
               stall_pct <= 19;
            end
         endcase
         phase_end = sent_count + 25;
         while (sent_count < phase_end) random_fragment();
      end
      req_tvalid <= 1'b0;

      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
